// ===== rtl/cds_pkg.sv =====
// ---------------------------------------------------------------------------
// CSV dialect sniffer package
// Shared sizes, opcodes, result codes and the result record.
// ---------------------------------------------------------------------------
package cds_pkg;

    localparam int MAX_BYTES   = 4096;
    localparam int ADDR_W      = $clog2(MAX_BYTES);
    localparam int POS_W       = ADDR_W + 1;
    localparam int MAX_LINES   = 10;
    localparam int LINE_W      = $clog2(MAX_LINES + 1);
    localparam int MAX_COLUMNS = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int NCOL_W      = COL_W + 1;
    localparam int N_CAND      = 5;
    localparam int TALLY_W     = POS_W;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_BYTE   = 2'd0;
    localparam t_opcode OP_EOL    = 2'd1;
    localparam t_opcode OP_FINISH = 2'd2;

    localparam logic [2:0] SEP_NONE   = 3'd0;
    localparam logic [2:0] SEP_SEMI   = 3'd1;
    localparam logic [2:0] SEP_COMMA  = 3'd2;
    localparam logic [2:0] SEP_PERIOD = 3'd3;
    localparam logic [2:0] SEP_TAB    = 3'd4;
    localparam logic [2:0] SEP_HYPHEN = 3'd5;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_APOS   = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [2:0] separator_code;
        logic [1:0] quote_code;
        logic       headers_present;
        logic       col_overflow;
    } t_result;

    // Separator byte for a separator code
    function automatic logic [7:0] sep_char(input logic [2:0] code);
        logic [7:0] c;
        unique case (code)
            SEP_SEMI:   c = 8'h3B;
            SEP_COMMA:  c = 8'h2C;
            SEP_PERIOD: c = 8'h2E;
            SEP_TAB:    c = 8'h09;
            SEP_HYPHEN: c = 8'h2D;
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/cds_buffer.sv =====
// ---------------------------------------------------------------------------
// CSV dialect sniffer sample buffer
// One write port, one registered read port over the sampled text bytes.
// ---------------------------------------------------------------------------
module cds_buffer (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [cds_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic [cds_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                o_rdata
);
    import cds_pkg::*;

    logic [7:0] r_mem [MAX_BYTES];
    logic [7:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cds_analyzer.sv =====
// ---------------------------------------------------------------------------
// CSV dialect sniffer analyzer
// Sequencer that walks the buffered lines byte by byte several times:
// separator counts, quote tallies, column syntax of line 1, checks of the
// lower lines and the header test on line 0.
// ---------------------------------------------------------------------------
module cds_analyzer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cds_pkg::LINE_W-1:0] i_num_lines,
    output logic [cds_pkg::LINE_W-1:0] o_line_idx,
    input  logic [cds_pkg::POS_W-1:0]  i_line_start,
    input  logic [cds_pkg::POS_W-1:0]  i_line_end,
    output logic [cds_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output logic                       o_done,
    input  logic                       i_ack,
    output cds_pkg::t_result           o_result
);
    import cds_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LINE, S_REQ, S_DAT, S_FEND, S_LEND, S_PICK, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_SEP, PH_QUOTE, PH_COL, PH_CHK, PH_HDR
    } t_phase;

    localparam int ENTRY_W = POS_W + 256;

    t_state             r_state;
    t_phase             r_phase;
    logic [LINE_W-1:0]  r_line;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_end;
    logic [POS_W-1:0]   r_fa;
    logic               r_last;
    logic [7:0]         r_first_b;
    logic [7:0]         r_prev_b;
    logic [255:0]       r_set;
    logic [POS_W-1:0]   r_cnt   [N_CAND];
    logic [POS_W-1:0]   r_first [N_CAND];
    logic [N_CAND-1:0]  r_cons;
    logic [2:0]         r_sep;
    logic [7:0]         r_sep_char;
    logic [TALLY_W-1:0] r_tally_apos;
    logic [TALLY_W-1:0] r_tally_dq;
    logic [NCOL_W-1:0]  r_k;
    logic [NCOL_W-1:0]  r_ncol;
    logic [MAX_COLUMNS-1:0] r_col_cons;
    logic               r_hdr;
    logic               r_covf;

    logic [ENTRY_W-1:0] r_col_mem [MAX_COLUMNS];
    logic [ENTRY_W-1:0] r_col_q;

    logic [POS_W-1:0]   flen;
    logic               differs;
    logic               is_digit;
    logic               col_we;
    logic               best_found;
    logic [2:0]         best_idx;
    logic               more_lines;
    logic [NCOL_W-1:0]  k_next;

    assign o_line_idx = r_line;
    assign o_rd_addr  = r_pos[ADDR_W-1:0];
    assign flen       = r_pos - r_fa;
    assign differs    = (r_col_q[ENTRY_W-1 -: POS_W] != flen) || (r_col_q[255:0] != r_set);
    assign is_digit   = (i_rd_data >= CH_ZERO) && (i_rd_data <= CH_NINE);
    assign col_we     = (r_state == S_FEND) && (r_phase == PH_COL)
                        && (r_ncol != NCOL_W'(MAX_COLUMNS));
    assign more_lines = (LINE_W'(r_line + 1'b1) < i_num_lines);
    assign k_next     = r_k + 1'b1;

    // Pick the largest consistent candidate, earliest on a tie
    always_comb begin
        best_found = 1'b0;
        best_idx   = 3'd0;
        for (int k = 0; k < N_CAND; k++) begin
            if (r_cons[k] && (!best_found || r_first[k] > r_first[best_idx])) begin
                best_found = 1'b1;
                best_idx   = 3'(k);
            end
        end
    end

    // Column store: one write, one registered read at the current column
    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_col_mem[r_ncol[COL_W-1:0]] <= {flen, r_set};
        end
        r_col_q <= r_col_mem[r_k[COL_W-1:0]];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_SEP;
            r_line  <= '0;
            r_k     <= '0;
            r_ncol  <= '0;
            r_sep   <= SEP_NONE;
            r_hdr   <= 1'b0;
            r_covf  <= 1'b0;
            r_cons  <= '1;
            r_tally_apos <= '0;
            r_tally_dq   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cons       <= '1;
                        r_sep        <= SEP_NONE;
                        r_hdr        <= 1'b0;
                        r_covf       <= 1'b0;
                        r_tally_apos <= '0;
                        r_tally_dq   <= '0;
                        r_k          <= '0;
                        r_ncol       <= '0;
                        r_phase      <= PH_SEP;
                        r_line       <= '0;
                        r_state      <= (i_num_lines == '0) ? S_DONE : S_LINE;
                    end
                end
                S_LINE: begin
                    r_pos <= i_line_start;
                    r_end <= i_line_end;
                    r_fa  <= i_line_start;
                    r_set <= '0;
                    for (int k = 0; k < N_CAND; k++) begin
                        r_cnt[k] <= '0;
                    end
                    r_state <= S_REQ;
                end
                S_REQ: begin
                    // Issue the read, or close the line
                    if (r_pos < r_end) begin
                        r_last  <= 1'b0;
                        r_state <= S_DAT;
                    end else if (r_phase == PH_SEP) begin
                        r_state <= S_LEND;
                    end else begin
                        r_last  <= 1'b1;
                        r_state <= S_FEND;
                    end
                end
                S_DAT: begin
                    if (r_phase == PH_SEP) begin
                        for (int k = 0; k < N_CAND; k++) begin
                            if (i_rd_data == sep_char(3'(k + 1))) begin
                                r_cnt[k] <= r_cnt[k] + 1'b1;
                            end
                        end
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_REQ;
                    end else if (i_rd_data == r_sep_char) begin
                        r_state <= S_FEND;
                    end else begin
                        if (r_pos == r_fa) begin
                            r_first_b <= i_rd_data;
                        end
                        r_prev_b <= i_rd_data;
                        if (!is_digit) begin
                            r_set[i_rd_data] <= 1'b1;
                        end
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_REQ;
                    end
                end
                S_FEND: begin
                    // Close one field; advance to the next field by default
                    if (r_last) begin
                        r_state <= S_LEND;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_fa    <= r_pos + 1'b1;
                        r_set   <= '0;
                        r_state <= S_REQ;
                    end
                    case (r_phase)
                        PH_QUOTE: begin
                            if (flen >= POS_W'(2) && r_first_b == r_prev_b) begin
                                if (r_first_b == CH_APOS) begin
                                    r_tally_apos <= r_tally_apos + 1'b1;
                                end else if (r_first_b == CH_DQUOTE) begin
                                    r_tally_dq <= r_tally_dq + 1'b1;
                                end
                            end
                        end
                        PH_COL: begin
                            if (r_ncol == NCOL_W'(MAX_COLUMNS)) begin
                                r_covf  <= 1'b1;
                                r_state <= S_LEND;
                            end else begin
                                r_col_cons[r_ncol[COL_W-1:0]] <= 1'b1;
                                r_ncol <= r_ncol + 1'b1;
                            end
                        end
                        PH_CHK: begin
                            if (r_col_cons[r_k[COL_W-1:0]] && differs) begin
                                r_col_cons[r_k[COL_W-1:0]] <= 1'b0;
                            end
                            r_k <= k_next;
                            if (k_next == r_ncol) begin
                                r_state <= S_LEND;
                            end
                        end
                        PH_HDR: begin
                            r_k <= k_next;
                            if (r_col_cons[r_k[COL_W-1:0]] && differs) begin
                                r_hdr   <= 1'b1;
                                r_state <= S_DONE;
                            end else if (k_next == r_ncol) begin
                                r_state <= S_LEND;
                            end
                        end
                        default: ;
                    endcase
                end
                S_LEND: begin
                    unique case (r_phase)
                        PH_SEP: begin
                            for (int k = 0; k < N_CAND; k++) begin
                                if (r_line == '0) begin
                                    r_first[k] <= r_cnt[k];
                                end else if (r_cnt[k] != r_first[k]) begin
                                    r_cons[k] <= 1'b0;
                                end
                            end
                            if (more_lines) begin
                                r_line  <= r_line + 1'b1;
                                r_state <= S_LINE;
                            end else begin
                                r_state <= S_PICK;
                            end
                        end
                        PH_QUOTE: begin
                            if (more_lines) begin
                                r_line  <= r_line + 1'b1;
                                r_state <= S_LINE;
                            end else if (i_num_lines >= LINE_W'(2)) begin
                                r_phase <= PH_COL;
                                r_line  <= LINE_W'(1);
                                r_state <= S_LINE;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        PH_COL: begin
                            r_k     <= '0;
                            r_state <= S_LINE;
                            if (i_num_lines > LINE_W'(2)) begin
                                r_phase <= PH_CHK;
                                r_line  <= LINE_W'(2);
                            end else begin
                                r_phase <= PH_HDR;
                                r_line  <= '0;
                            end
                        end
                        PH_CHK: begin
                            r_k     <= '0;
                            r_state <= S_LINE;
                            if (more_lines) begin
                                r_line <= r_line + 1'b1;
                            end else begin
                                r_phase <= PH_HDR;
                                r_line  <= '0;
                            end
                        end
                        PH_HDR: begin
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_PICK: begin
                    if (best_found) begin
                        r_sep      <= best_idx + 3'd1;
                        r_sep_char <= sep_char(best_idx + 3'd1);
                        r_phase    <= PH_QUOTE;
                        r_line     <= '0;
                        r_state    <= S_LINE;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Report
    always_comb begin
        o_done                   = (r_state == S_DONE);
        o_result.separator_code  = r_sep;
        o_result.headers_present = r_hdr;
        o_result.col_overflow    = r_covf;
        if (r_tally_apos == '0 && r_tally_dq == '0) begin
            o_result.quote_code = QUOTE_NONE;
        end else if (r_tally_apos > r_tally_dq) begin
            o_result.quote_code = QUOTE_APOS;
        end else begin
            o_result.quote_code = QUOTE_DOUBLE;
        end
    end

    a_dat_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DAT) |-> ($past(r_state) == S_REQ))
        else $error("byte processed without a read request");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= r_ncol)
        else $error("column index past the column count");

    a_sep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.separator_code <= SEP_HYPHEN))
        else $error("separator code out of range");

    a_no_sep_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.separator_code == SEP_NONE) |->
        (o_result.quote_code == QUOTE_NONE && !o_result.headers_present))
        else $error("quote or header reported without a separator");

endmodule

// ===== rtl/csv_dialect_sniffer_top.sv =====
// ---------------------------------------------------------------------------
// CSV dialect sniffer
// Buffers a sample of text lines and reports separator, quote, header flag.
// ---------------------------------------------------------------------------
// Usage:
//   Input words carry an opcode and a byte: text byte, end of line, or
//   finish. Text bytes and line ends are taken one per cycle while o_in_stall
//   is low and stored in a 4096-byte buffer and a line table. Lines past
//   sample_lines are ignored; bytes past a full buffer are dropped and flag
//   overflow. A finish word starts the analysis: o_in_stall stays high while
//   the sequencer walks the buffer byte by byte through the buffer's
//   registered read port, on each of three walks: counts, quotes and the
//   column checks.
//   The result word then sits in the output register until taken; while
//   the receiver stalls it holds and new text words are still taken.
//   A second finish waits in the analyzer until the output frees up.
//   The configuration channel writes sample_lines (reset value 10) and is
//   always ready; write it only while no sample is under analysis.
//   Reset clears the sample, the input overflow flag and the output valid flag; no
//   clearing pass over the buffer is needed.
// ---------------------------------------------------------------------------
module csv_dialect_sniffer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_char_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_separator_code,
    output logic [1:0] o_quote_code,
    output logic       o_headers_present,
    output logic       o_overflow,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data
);
    import cds_pkg::*;

    logic [3:0]        r_sample_lines;
    logic [LINE_W-1:0] r_line_count;
    logic [POS_W-1:0]  r_byte_count;
    logic [POS_W-1:0]  r_line_start;
    logic              r_line_open;
    logic              r_overflow;
    logic              r_busy;
    logic              r_start;
    logic              r_out_valid;
    logic [2:0]        r_sep;
    logic [1:0]        r_quote;
    logic              r_hdr;
    logic              r_ovf_out;
    logic [POS_W-1:0]  r_start_tab [MAX_LINES];
    logic [POS_W-1:0]  r_end_tab   [MAX_LINES];

    logic              accept;
    logic [LINE_W-1:0] lim;
    logic              line_room;
    logic              close_line;
    logic              buf_we;
    logic              load;
    logic [LINE_W-1:0] ana_line;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              ana_done;
    t_result           ana_res;

    assign o_in_stall = r_busy;
    assign o_cfg_ready = 1'b1;
    assign accept     = i_in_valid & ~o_in_stall;
    assign lim        = (r_sample_lines > 4'(MAX_LINES)) ? LINE_W'(MAX_LINES)
                                                         : LINE_W'(r_sample_lines);
    assign line_room  = r_line_count < lim;
    assign close_line = accept & line_room &
                        ((i_opcode == OP_EOL) | ((i_opcode == OP_FINISH) & r_line_open));
    assign buf_we     = accept & line_room & (i_opcode == OP_BYTE)
                        & (r_byte_count < POS_W'(MAX_BYTES));
    assign load       = ana_done & (~r_out_valid | ~i_out_stall);

    cds_buffer u_buffer (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_byte_count[ADDR_W-1:0]),
        .i_wdata (i_char_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    cds_analyzer u_analyzer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_start),
        .i_num_lines  (r_line_count),
        .o_line_idx   (ana_line),
        .i_line_start (r_start_tab[ana_line]),
        .i_line_end   (r_end_tab[ana_line]),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_done       (ana_done),
        .i_ack        (load),
        .o_result     (ana_res)
    );

    // Line table: record bounds of each closed line
    always_ff @(posedge i_clk) begin
        if (close_line) begin
            r_start_tab[r_line_count] <= r_line_start;
            r_end_tab[r_line_count]   <= r_byte_count;
        end
    end

    // Load control, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_lines <= 4'(MAX_LINES);
            r_line_count   <= '0;
            r_byte_count   <= '0;
            r_line_start   <= '0;
            r_line_open    <= 1'b0;
            r_overflow     <= 1'b0;
            r_busy         <= 1'b0;
            r_start        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_valid & o_cfg_ready) begin
                r_sample_lines <= i_cfg_data;
            end
            if (accept & line_room & (i_opcode == OP_BYTE)) begin
                r_line_open <= 1'b1;
                if (buf_we) begin
                    r_byte_count <= r_byte_count + 1'b1;
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (close_line) begin
                r_line_count <= r_line_count + 1'b1;
                r_line_start <= r_byte_count;
                r_line_open  <= 1'b0;
            end
            if (accept & (i_opcode == OP_FINISH)) begin
                r_busy  <= 1'b1;
                r_start <= 1'b1;
            end
            // Hand the result over and clear the sample
            if (load) begin
                r_out_valid  <= 1'b1;
                r_sep        <= ana_res.separator_code;
                r_quote      <= ana_res.quote_code;
                r_hdr        <= ana_res.headers_present;
                r_ovf_out    <= r_overflow | ana_res.col_overflow;
                r_busy       <= 1'b0;
                r_line_count <= '0;
                r_byte_count <= '0;
                r_line_start <= '0;
                r_line_open  <= 1'b0;
                r_overflow   <= 1'b0;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_separator_code  = r_sep;
    assign o_quote_code      = r_quote;
    assign o_headers_present = r_hdr;
    assign o_overflow        = r_ovf_out;

endmodule
